FILE: hw/rtl/adam_optimizer_update_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Adam update block
// Implication checks clocked on clk and masked during reset.
// ---------------------------------------------------------------------------
`ifndef ADAM_OPTIMIZER_UPDATE_TOP_ASSERT_SVH
`define ADAM_OPTIMIZER_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication
`define ADAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ADAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/adam_pkg.sv
// ---------------------------------------------------------------------------
// adam_pkg
// Shared widths, register indexes, pipeline stage types and step functions.
// ---------------------------------------------------------------------------
package adam_pkg;

  localparam int ELEMENT_COUNT = 4096;
  localparam int ADDR_W        = $clog2(ELEMENT_COUNT);
  localparam int IDX_W         = 12;
  localparam int VAL_W         = 32;
  localparam int M_W           = 32;
  localparam int V_W           = 48;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int SQ_N          = 32;
  localparam int NUM_W         = 56;
  localparam int DEN_W         = 33;
  localparam int CLR_W         = ADDR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BETA_ONE   = 3'd0,
    REG_BETA_TWO   = 3'd1,
    REG_FIRST_CORR = 3'd2,
    REG_SECOND_CORR = 3'd3,
    REG_LRATE      = 3'd4,
    REG_EPSILON    = 3'd5,
    REG_CORR_EN    = 3'd6
  } reg_idx_t;

  // after accept: squared gradient magnitude
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        raw_idx;
    logic signed [VAL_W-1:0] p;
    logic signed [VAL_W-1:0] g;
    logic [63:0]             gg;
  } s0_t;

  // gradient terms of both moment updates
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        raw_idx;
    logic signed [VAL_W-1:0] p;
    logic signed [49:0]      mterm;
    logic [63:0]             vterm;
  } s1_t;

  // new moments, as written back
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        raw_idx;
    logic signed [VAL_W-1:0] p;
    logic signed [M_W-1:0]   mn;
    logic [V_W-1:0]          vn;
  } s2_t;

  // correction products
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        raw_idx;
    logic signed [VAL_W-1:0] p;
    logic                    mneg;
    logic [M_W-1:0]          mmag;
    logic [V_W-1:0]          vn;
    logic [63:0]             mprod;
    logic [63:0]             vlo;
    logic [47:0]             vhi;
  } s3_t;

  // one root digit per stage
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        raw_idx;
    logic signed [VAL_W-1:0] p;
    logic                    mneg;
    logic [M_W-1:0]          mmag;
    logic [63:0]             x;
    logic [32:0]             rem;
    logic [31:0]             root;
  } sq_t;

  // one quotient bit per stage
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        raw_idx;
    logic signed [VAL_W-1:0] p;
    logic                    mneg;
    logic [NUM_W-1:0]        num;
    logic [DEN_W-1:0]        den;
    logic [DEN_W-1:0]        rem;
    logic [NUM_W-1:0]        quo;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t s);
    sq_t         r;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    r      = s;
    rem_sh = {s.rem, s.x[63:62]};
    trial  = {1'b0, s.root, 2'b01};
    if (rem_sh >= trial) begin
      r.rem  = 33'(rem_sh - trial);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem_sh[32:0];
      r.root = {s.root[30:0], 1'b0};
    end
    r.x = {s.x[61:0], 2'b00};
    return r;
  endfunction

  function automatic dv_t div_step(input dv_t d);
    dv_t            r;
    logic [DEN_W:0] rem_sh;
    r      = d;
    rem_sh = {d.rem, d.num[NUM_W-1]};
    if (rem_sh >= {1'b0, d.den}) begin
      r.rem = DEN_W'(rem_sh - {1'b0, d.den});
      r.quo = {d.quo[NUM_W-2:0], 1'b1};
    end else begin
      r.rem = rem_sh[DEN_W-1:0];
      r.quo = {d.quo[NUM_W-2:0], 1'b0};
    end
    r.num = {d.num[NUM_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

FILE: hw/rtl/adam_in_if.sv
// ---------------------------------------------------------------------------
// adam_in_if
// Input channel: element index, parameter and gradient per beat.
// ---------------------------------------------------------------------------
interface adam_in_if import adam_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        element_index;
  logic signed [VAL_W-1:0] param_value;
  logic signed [VAL_W-1:0] gradient;

  modport source (output valid, element_index, param_value, gradient, input ready);
  modport sink   (input valid, element_index, param_value, gradient, output ready);
endinterface

FILE: hw/rtl/adam_out_if.sv
// ---------------------------------------------------------------------------
// adam_out_if
// Result channel: echoed index and updated parameter per beat.
// ---------------------------------------------------------------------------
interface adam_out_if import adam_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        result_index;
  logic signed [VAL_W-1:0] new_param;

  modport source (output valid, result_index, new_param, input ready);
  modport sink   (input valid, result_index, new_param, output ready);
endinterface

FILE: hw/rtl/adam_ram.sv
// ---------------------------------------------------------------------------
// adam_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module adam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: hw/rtl/adam_optimizer_update_top.sv
// ---------------------------------------------------------------------------
// adam_optimizer_update_top
// Adam parameter update with moment stores held in on-chip RAM.
// ---------------------------------------------------------------------------
// One element is accepted per cycle while the output register can take a beat
// and no clearing pass runs. The moments live in two RAMs, read one stage after
// accept and written back one stage later; a back-to-back hit on the same element
// is forwarded from the write-back register. The latency is set by the 32-stage
// square root and the 56-stage divider. After reset a clearing pass zeroes both
// RAMs, during which no input beat is taken.
`include "adam_optimizer_update_top_assert.svh"

module adam_optimizer_update_top import adam_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  adam_in_if.sink               in_ch,
  adam_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] beta_one_r, beta_two_r;
  logic [31:0] first_corr_r, second_corr_r;
  logic [23:0] lrate_r, eps_r;
  logic        corr_en_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_one_r    <= 16'd58982;
      beta_two_r    <= 16'd65470;
      first_corr_r  <= 32'd1048576;
      second_corr_r <= 32'd1048576;
      lrate_r       <= 24'd16777;
      eps_r         <= 24'd2;
      corr_en_r     <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BETA_ONE:    beta_one_r    <= cfg_data[15:0];
        REG_BETA_TWO:    beta_two_r    <= cfg_data[15:0];
        REG_FIRST_CORR:  first_corr_r  <= cfg_data;
        REG_SECOND_CORR: second_corr_r <= cfg_data;
        REG_LRATE:       lrate_r       <= cfg_data[23:0];
        REG_EPSILON:     eps_r         <= cfg_data[23:0];
        REG_CORR_EN:     corr_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  logic [CLR_W-1:0] clr_cnt_r;
  logic             clr_active;
  assign clr_active = !clr_cnt_r[CLR_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clr_active) begin
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  // global advance: the output register can take a beat
  logic out_valid_r;
  logic adv;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv && !clr_active;

  s0_t s0_r, s0_nxt;
  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  sq_t sq_r [0:SQ_N];
  sq_t sq0_nxt;
  dv_t dv_r [0:NUM_W];
  dv_t dv0_nxt;

  // accept: gradient magnitude squared
  logic [VAL_W-1:0] gmag;
  always_comb begin
    gmag           = in_ch.gradient[VAL_W-1] ? VAL_W'(-in_ch.gradient) : in_ch.gradient;
    s0_nxt.valid   = in_ch.valid && in_ch.ready;
    s0_nxt.raw_idx = in_ch.element_index;
    s0_nxt.p       = in_ch.param_value;
    s0_nxt.g       = in_ch.gradient;
    s0_nxt.gg      = 64'(gmag) * 64'(gmag);
  end

  // gradient terms, RAM read issued from s0
  logic [16:0]        omb1, omb2;
  logic signed [17:0] omb1_s;
  logic [46:0]        g2;
  always_comb begin
    omb1           = 17'd65536 - 17'(beta_one_r);
    omb2           = 17'd65536 - 17'(beta_two_r);
    omb1_s         = {1'b0, omb1};
    g2             = 47'((s0_r.gg + 64'd32768) >> 16);
    s1_nxt.valid   = s0_r.valid;
    s1_nxt.raw_idx = s0_r.raw_idx;
    s1_nxt.p       = s0_r.p;
    s1_nxt.mterm   = omb1_s * s0_r.g;
    s1_nxt.vterm   = 64'(omb2) * 64'(g2);
  end

  // moment stores
  logic [M_W-1:0]    m_rd;
  logic [V_W-1:0]    v_rd;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [M_W-1:0]    m_wdata;
  logic [V_W-1:0]    v_wdata;

  assign mem_we    = clr_active || (adv && s1_r.valid);
  assign mem_waddr = clr_active ? clr_cnt_r[ADDR_W-1:0] : s1_r.raw_idx[ADDR_W-1:0];
  assign m_wdata   = clr_active ? '0 : s2_nxt.mn;
  assign v_wdata   = clr_active ? '0 : s2_nxt.vn;

  adam_ram #(.WIDTH(M_W), .DEPTH(ELEMENT_COUNT)) u_m_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (m_wdata),
    .re    (adv),
    .raddr (s0_r.raw_idx[ADDR_W-1:0]),
    .rdata (m_rd)
  );

  adam_ram #(.WIDTH(V_W), .DEPTH(ELEMENT_COUNT)) u_v_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (v_wdata),
    .re    (adv),
    .raddr (s0_r.raw_idx[ADDR_W-1:0]),
    .rdata (v_rd)
  );

  // moment update with forwarding of the previous write-back
  logic                  fwd_hit;
  logic signed [M_W-1:0] m_cur;
  logic [V_W-1:0]        v_cur;
  logic signed [50:0]    msum, mfull;
  logic [65:0]           vsum;
  always_comb begin
    fwd_hit = s2_r.valid && (s2_r.raw_idx[ADDR_W-1:0] == s1_r.raw_idx[ADDR_W-1:0]);
    m_cur   = fwd_hit ? s2_r.mn : m_rd;
    v_cur   = fwd_hit ? s2_r.vn : v_rd;
    msum    = $signed({1'b0, beta_one_r}) * m_cur + s1_r.mterm;
    mfull   = (msum + 51'sd32768) >>> 16;
    vsum    = 66'(beta_two_r) * 66'(v_cur) + 66'(s1_r.vterm) + 66'd32768;
    s2_nxt.valid   = s1_r.valid;
    s2_nxt.raw_idx = s1_r.raw_idx;
    s2_nxt.p       = s1_r.p;
    if (mfull > 51'sd2147483647) begin
      s2_nxt.mn = 32'sh7FFFFFFF;
    end else if (mfull < -51'sd2147483648) begin
      s2_nxt.mn = 32'sh80000000;
    end else begin
      s2_nxt.mn = mfull[31:0];
    end
    s2_nxt.vn = vsum[63:16];
  end

  // correction products
  always_comb begin
    s3_nxt.valid   = s2_r.valid;
    s3_nxt.raw_idx = s2_r.raw_idx;
    s3_nxt.p       = s2_r.p;
    s3_nxt.mneg    = s2_r.mn[M_W-1];
    s3_nxt.mmag    = s2_r.mn[M_W-1] ? M_W'(-s2_r.mn) : s2_r.mn;
    s3_nxt.vn      = s2_r.vn;
    s3_nxt.mprod   = 64'(s3_nxt.mmag) * 64'(first_corr_r);
    s3_nxt.vlo     = 64'(s2_r.vn[31:0]) * 64'(second_corr_r);
    s3_nxt.vhi     = 48'(s2_r.vn[47:32]) * 48'(second_corr_r);
  end

  // select and saturate corrected moments, seed the root
  logic [43:0] mc;
  logic [43:0] mlim;
  logic [60:0] vc;
  logic [V_W-1:0] vhat;
  always_comb begin
    mc   = corr_en_r ? 44'(s3_r.mprod >> 20) : 44'(s3_r.mmag);
    mlim = s3_r.mneg ? 44'h0_0080000000 : 44'h0_007FFFFFFF;
    vc   = corr_en_r ? (61'({s3_r.vhi, 12'b0}) + 61'(s3_r.vlo >> 20)) : 61'(s3_r.vn);
    vhat = (vc > 61'(48'hFFFFFFFFFFFF)) ? 48'hFFFFFFFFFFFF : vc[47:0];
    sq0_nxt.valid   = s3_r.valid;
    sq0_nxt.raw_idx = s3_r.raw_idx;
    sq0_nxt.p       = s3_r.p;
    sq0_nxt.mneg    = s3_r.mneg;
    sq0_nxt.mmag    = (mc > mlim) ? mlim[31:0] : mc[31:0];
    sq0_nxt.x       = {vhat, 16'b0};
    sq0_nxt.rem     = '0;
    sq0_nxt.root    = '0;
  end

  // numerator and divisor from the root
  logic [DEN_W-1:0] den_raw;
  always_comb begin
    den_raw         = DEN_W'(sq_r[SQ_N].root) + DEN_W'(eps_r);
    dv0_nxt.valid   = sq_r[SQ_N].valid;
    dv0_nxt.raw_idx = sq_r[SQ_N].raw_idx;
    dv0_nxt.p       = sq_r[SQ_N].p;
    dv0_nxt.mneg    = sq_r[SQ_N].mneg;
    dv0_nxt.num     = NUM_W'(lrate_r) * NUM_W'(sq_r[SQ_N].mmag);
    dv0_nxt.den     = (den_raw == '0) ? DEN_W'(1) : den_raw;
    dv0_nxt.rem     = '0;
    dv0_nxt.quo     = '0;
  end

  // front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid    <= 1'b0;
      s1_r.valid    <= 1'b0;
      s2_r.valid    <= 1'b0;
      s3_r.valid    <= 1'b0;
      sq_r[0].valid <= 1'b0;
      dv_r[0].valid <= 1'b0;
    end else if (adv) begin
      s0_r    <= s0_nxt;
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      s3_r    <= s3_nxt;
      sq_r[0] <= sq0_nxt;
      dv_r[0] <= dv0_nxt;
    end
  end

  // root digits
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k+1].valid <= 1'b0;
      end else if (adv) begin
        sq_r[k+1] <= sqrt_step(sq_r[k]);
      end
    end
  end

  // quotient bits
  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1].valid <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= div_step(dv_r[k]);
      end
    end
  end

  // apply the signed step and saturate
  logic signed [57:0] p_ext, q_ext, np;
  logic signed [VAL_W-1:0] np_sat;
  always_comb begin
    p_ext = 58'(dv_r[NUM_W].p);
    q_ext = $signed({2'b00, dv_r[NUM_W].quo});
    np    = dv_r[NUM_W].mneg ? (p_ext + q_ext) : (p_ext - q_ext);
    if (np > 58'sd2147483647) begin
      np_sat = 32'sh7FFFFFFF;
    end else if (np < -58'sd2147483648) begin
      np_sat = 32'sh80000000;
    end else begin
      np_sat = np[31:0];
    end
  end

  // output register
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [VAL_W-1:0] out_param_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[NUM_W].valid;
      out_idx_r   <= dv_r[NUM_W].raw_idx;
      out_param_r <= np_sat;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.new_param    = out_param_r;

  // checks
  `ADAM_ASSERT_NOW(a_no_accept_clear, clr_active, !in_ch.ready, "beat taken during clear")
  `ADAM_ASSERT_NOW(a_no_wb_clear, clr_active, !s1_r.valid, "write-back during clear")
  `ADAM_ASSERT_NOW(a_stall_blocks, out_valid_r && !out_ch.ready, !in_ch.ready,
    "input taken while output stalled")
  `ADAM_ASSERT_NEXT(a_stall_hold, !adv, $stable(s2_r) && $stable(sq_r[SQ_N]),
    "pipeline moved while stalled")

endmodule
